/* rtl/lsbbb_pkg.sv */
// Shared constants, types and codes for the LSB-first bitstream buffer.
package lsbbb_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY_BYTES = 4096;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned CAP_BITS       = CAPACITY_BYTES * 8;
  localparam int unsigned MEM_WORDS      = CAP_BITS / WORD_BITS;
  localparam int unsigned ADDR_W         = $clog2(MEM_WORDS);

  // Field widths of the transaction payloads.
  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 15;
  localparam int unsigned FW_W  = 7;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned OFF_W = $clog2(WORD_BITS);

  // Command codes; code 3 has no meaning and is refused.
  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_APPEND = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_MERGE,
    S_WR_HI,
    S_RESP
  } state_e;

  // One access to the word memory.
  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } ram_req_t;

endpackage

/* rtl/lsbbb_ram.sv */
// Single-port word memory with a registered read, holding the bitstream.
module lsbbb_ram (
  input  logic                      clk_i,
  input  lsbbb_pkg::ram_req_t       req_i,
  output logic [lsbbb_pkg::WORD_BITS-1:0] rdata_o
);
  import lsbbb_pkg::*;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  // One access per cycle: either a write or a read.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lsbbb_merge.sv */
// Field extract and insert across a pair of adjacent memory words.
module lsbbb_merge (
  input  logic [lsbbb_pkg::WORD_BITS-1:0] lo_i,
  input  logic [lsbbb_pkg::WORD_BITS-1:0] hi_i,
  input  logic [lsbbb_pkg::OFF_W-1:0]     off_i,
  input  logic [lsbbb_pkg::FW_W-1:0]      width_i,
  input  logic [lsbbb_pkg::WORD_BITS-1:0] wval_i,
  output logic [lsbbb_pkg::WORD_BITS-1:0] rd_val_o,
  output logic [lsbbb_pkg::WORD_BITS-1:0] new_lo_o,
  output logic [lsbbb_pkg::WORD_BITS-1:0] new_hi_o
);
  import lsbbb_pkg::*;

  logic [WORD_BITS-1:0]   fmask;
  logic [2*WORD_BITS-1:0] pair;
  logic [2*WORD_BITS-1:0] window;
  logic [2*WORD_BITS-1:0] ins_mask;
  logic [2*WORD_BITS-1:0] ins_val;
  logic [2*WORD_BITS-1:0] merged;

  // Mask of the low width bits; a full-width field sets every bit.
  always_comb begin
    if (width_i[FW_W-1]) begin
      fmask = '1;
    end else begin
      fmask = (WORD_BITS'(1) << width_i[FW_W-2:0]) - WORD_BITS'(1);
    end
  end

  // Extract: shift the word pair down to the field start.
  assign pair     = {hi_i, lo_i};
  assign window   = pair >> off_i;
  assign rd_val_o = window[WORD_BITS-1:0] & fmask;

  // Insert: replace the field bits, keep the rest of both words.
  assign ins_mask = {{WORD_BITS{1'b0}}, fmask} << off_i;
  assign ins_val  = {{WORD_BITS{1'b0}}, wval_i & fmask} << off_i;
  assign merged   = (pair & ~ins_mask) | ins_val;
  assign new_lo_o = merged[WORD_BITS-1:0];
  assign new_hi_o = merged[2*WORD_BITS-1:WORD_BITS];

endmodule

/* rtl/lsb_first_bitstream_buffer_core.sv */
// Top level of the LSB-first bitstream buffer: command sequencer and result register.
//
// Each input transaction is one command: get reads a field of 0 to 64 bits at
// bit_index_i, set overwrites such a field in place, append adds one at the
// end of the stream. Bit k of the stream is bit k mod 8 of byte k / 8. Every
// command yields exactly one output transaction with the field read, the bit
// count after the command and an error flag; a refused command changes nothing.
// The stream lives in a 512 x 64-bit single-port memory with a registered
// read. A field covers at most two words, so a command reads both words and
// merges; a set or append then writes back the low word and, when the field
// crosses into it, the high word. The single memory port sets the pace: the
// states run read low, read high, merge, a high-word write only for a set or
// append that crosses a word boundary, then the result; a refused or zero-width
// command goes straight to the result. One command is in flight at a time;
// in_stall_o is high from acceptance until the result is loaded. The result
// register lets the next command be accepted while a result still waits; when
// out_stall_i holds it, a finished command waits before loading its result.
// Reset clears the bit count and all valid flags; the memory needs no clearing pass.
module lsb_first_bitstream_buffer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lsbbb_pkg::CMD_W-1:0]       cmd_i,
  input  logic [lsbbb_pkg::IDX_W-1:0]       bit_index_i,
  input  logic [lsbbb_pkg::FW_W-1:0]        field_width_i,
  input  logic [lsbbb_pkg::WORD_BITS-1:0]   write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lsbbb_pkg::WORD_BITS-1:0]   read_value_o,
  output logic [lsbbb_pkg::LEN_W-1:0]       bit_count_o,
  output logic                              error_o
);
  import lsbbb_pkg::*;

  state_e               state_q, state_d;
  logic [LEN_W-1:0]     len_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [FW_W-1:0]      w_q;
  logic [WORD_BITS-1:0] val_q;
  logic                 err_q;
  logic [OFF_W-1:0]     off_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 cross_q;
  logic [WORD_BITS-1:0] lo_q;
  logic [WORD_BITS-1:0] new_hi_q;
  logic [WORD_BITS-1:0] rd_q;

  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_val_q;
  logic [LEN_W-1:0]     out_len_q;
  logic                 out_err_q;

  logic                 accept;
  logic                 resp_load;
  logic                 err_d;
  logic [IDX_W-1:0]     pos;
  logic [LEN_W:0]       end_get;
  logic [LEN_W:0]       end_app;
  logic [OFF_W+1:0]     off_end;
  logic [ADDR_W-1:0]    addr_hi;
  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] rd_val;
  logic [WORD_BITS-1:0] new_lo;
  logic [WORD_BITS-1:0] new_hi;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign resp_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign addr_hi    = ADDR_W'(addr_q + ADDR_W'(1));

  // Range and code checks on the incoming command.
  assign end_get = (LEN_W+1)'(bit_index_i) + (LEN_W+1)'(field_width_i);
  assign end_app = (LEN_W+1)'(len_q) + (LEN_W+1)'(field_width_i);

  always_comb begin
    err_d = field_width_i[FW_W-1] && (field_width_i[FW_W-2:0] != '0);
    case (cmd_i)
      CMD_GET, CMD_SET: begin
        if (end_get > (LEN_W+1)'(len_q)) err_d = 1'b1;
      end
      CMD_APPEND: begin
        if (end_app > (LEN_W+1)'(CAP_BITS)) err_d = 1'b1;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  // Get and set start at the given bit; append starts at the stream end.
  assign pos     = (cmd_i == CMD_APPEND) ? len_q[IDX_W-1:0] : bit_index_i;
  assign off_end = (OFF_W+2)'(pos[OFF_W-1:0]) + (OFF_W+2)'(field_width_i);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_d       = state_q;
    ram_req.en    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = addr_q;
    ram_req.wdata = new_lo;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (err_d || (field_width_i == '0)) ? S_RESP : S_RD_LO;
        end
      end
      S_RD_LO: begin
        ram_req.en = 1'b1;
        state_d    = S_RD_HI;
      end
      S_RD_HI: begin
        ram_req.en   = 1'b1;
        ram_req.addr = addr_hi;
        state_d      = S_MERGE;
      end
      S_MERGE: begin
        if (cmd_q == CMD_GET) begin
          state_d = S_RESP;
        end else begin
          ram_req.en = 1'b1;
          ram_req.we = 1'b1;
          state_d    = cross_q ? S_WR_HI : S_RESP;
        end
      end
      S_WR_HI: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = addr_hi;
        ram_req.wdata = new_hi_q;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (resp_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command registers and word staging.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      w_q     <= field_width_i;
      val_q   <= write_value_i;
      err_q   <= err_d;
      off_q   <= pos[OFF_W-1:0];
      addr_q  <= pos[IDX_W-1:OFF_W];
      cross_q <= off_end > (OFF_W+2)'(WORD_BITS);
      rd_q    <= '0;
    end
    if (state_q == S_RD_HI) lo_q <= ram_rdata;
    if (state_q == S_MERGE) begin
      new_hi_q <= new_hi;
      if (cmd_q == CMD_GET) rd_q <= rd_val;
    end
  end

  // Stream length grows when an append commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if ((state_q == S_MERGE) && (cmd_q == CMD_APPEND)) begin
      len_q <= LEN_W'(len_q + LEN_W'(w_q));
    end
  end

  // Output transaction register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_val_q <= rd_q;
      out_len_q <= len_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign bit_count_o  = out_len_q;
  assign error_o      = out_err_q;

  lsbbb_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // The high word arrives from memory during the merge cycle.
  lsbbb_merge u_merge (
    .lo_i     (lo_q),
    .hi_i     (ram_rdata),
    .off_i    (off_q),
    .width_i  (w_q),
    .wval_i   (val_q),
    .rd_val_o (rd_val),
    .new_lo_o (new_lo),
    .new_hi_o (new_hi)
  );

endmodule
